### hw/rtl/cbq_pkg.sv
// Shared constants and types for the cascaded biquad core.
package cbq_pkg;

  localparam int DATA_W            = 16;
  localparam int ACC_W             = 32;
  localparam int IDX_W             = 5;
  localparam int CFG_W             = 3;
  localparam int COEFS_PER_SECTION = 5;
  localparam int MAX_SECTIONS_DEF  = 4;

  localparam int IN_SHIFT = 12;
  localparam int W0_LSB   = 15;
  localparam int OUT_LSB  = 12;

  localparam logic [ACC_W-1:0] W0_ROUND  = 32'h0000_4000;
  localparam logic [ACC_W-1:0] OUT_ROUND = 32'h0000_0800;

  // Coefficient order inside one section's slot group.
  localparam int POS_A1 = 0;
  localparam int POS_A2 = 1;
  localparam int POS_B2 = 2;
  localparam int POS_B0 = 3;
  localparam int POS_B1 = 4;

  localparam logic [CFG_W-1:0] NUM_SECTIONS_RST = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A1,
    ST_A2,
    ST_W0,
    ST_B0,
    ST_B1,
    ST_DONE
  } cbq_step_t;

  typedef enum logic {
    CORE_IDLE,
    CORE_BUSY
  } cbq_core_state_t;

  // Coefficient write broadcast along the chain.
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } cbq_coef_wr_t;

endpackage

### hw/rtl/cbq_ifs.sv
// Channel interfaces: sample/coefficient input, filtered output, register write.
interface cbq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [cbq_pkg::DATA_W-1:0] sample_in;
  logic                              last_in;
  logic [cbq_pkg::IDX_W-1:0]         coef_index;
  logic signed [cbq_pkg::DATA_W-1:0] coef_value;

  modport source (output valid, command, sample_in, last_in, coef_index, coef_value,
                  input ready);
  modport sink (input valid, command, sample_in, last_in, coef_index, coef_value,
                output ready);
endinterface

interface cbq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbq_pkg::DATA_W-1:0] sample_out;
  logic                              last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink (input valid, sample_out, last_out, output ready);
endinterface

interface cbq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cbq_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/cascaded_biquad_iir_q15_core.sv
// Cascaded direct-form-II biquad filter, Q2.14 coefficients, chain of section cells.
// Each sample passes through the first num_sections cells (at most MAX_SECTIONS)
// in turn; a cell computes five products on its one 16x16 multiplier, then hands
// its accumulator to the next cell. With no section in use a sample goes straight
// to the output register. The input takes one transaction at a time, so a new
// sample is taken only once the previous one has left the chain and the skid
// stage is empty; a coefficient word is written in the cycle it is accepted. A
// finished result waits in an output register with a one-deep skid stage, so the
// next sample can start while the previous result is unread.
// num_sections may only be rewritten while no sample is in flight.
module cascaded_biquad_iir_q15_core #(
  parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF
) (
  input logic      clk,
  input logic      rst,
  cbq_in_if.sink   samples,
  cbq_out_if.source results,
  cbq_cfg_if.sink  cfg
);
  import cbq_pkg::*;

  localparam int USED_W = $clog2(MAX_SECTIONS + 1);

  cbq_core_state_t          state, state_next;
  logic [CFG_W-1:0]         num_sections;
  logic [USED_W-1:0]        used;
  logic                     sample_acc;
  logic                     bypass;
  cbq_coef_wr_t             coef_wr;
  logic [MAX_SECTIONS-1:0]  cell_start;
  logic [MAX_SECTIONS-1:0]  cell_done;
  logic [ACC_W-1:0]         cell_acc [MAX_SECTIONS];
  logic [ACC_W-1:0]         acc_first;
  logic                     chain_fin;
  logic [ACC_W-1:0]         chain_acc;
  logic                     fin;
  logic [ACC_W-1:0]         fin_acc;
  logic                     last_hold;
  logic                     fin_last;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_data;
  logic                     out_last;
  logic                     skid_valid;
  logic [DATA_W-1:0]        skid_data;
  logic                     skid_last;
  logic                     pop;

  // Register port.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= NUM_SECTIONS_RST;
    end else if (cfg.valid) begin
      num_sections <= cfg.data;
    end
  end

  assign used = (int'(num_sections) > MAX_SECTIONS) ? USED_W'(MAX_SECTIONS)
                                                      : USED_W'(num_sections);

  assign samples.ready = (state == CORE_IDLE) && !skid_valid;
  assign sample_acc    = samples.valid && samples.ready && !samples.command;
  assign bypass        = sample_acc && (used == '0);

  assign coef_wr.en    = samples.valid && samples.ready && samples.command;
  assign coef_wr.index = samples.coef_index;
  assign coef_wr.value = samples.coef_value;

  assign acc_first = ACC_W'(samples.sample_in) << IN_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CORE_IDLE: if (sample_acc && !bypass) state_next = CORE_BUSY;
      CORE_BUSY: if (chain_fin) state_next = CORE_IDLE;
      default:   state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sample_acc) last_hold <= samples.last_in;
  end

  // Accumulator passes down the chain; unused tail cells never start.
  generate
    for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign cell_start[i] = sample_acc && !bypass;
        cbq_cell #(.SECTION_IDX(i)) u_cell (
          .clk     (clk),
          .rst     (rst),
          .start   (cell_start[i]),
          .acc_in  (acc_first),
          .coef_wr (coef_wr),
          .done    (cell_done[i]),
          .acc_out (cell_acc[i])
        );
      end else begin : g_body
        assign cell_start[i] = cell_done[i-1] && (i < int'(used));
        cbq_cell #(.SECTION_IDX(i)) u_cell (
          .clk     (clk),
          .rst     (rst),
          .start   (cell_start[i]),
          .acc_in  (cell_acc[i-1]),
          .coef_wr (coef_wr),
          .done    (cell_done[i]),
          .acc_out (cell_acc[i])
        );
      end
    end
  endgenerate

  always_comb begin
    chain_fin = 1'b0;
    chain_acc = cell_acc[0];
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (cell_done[i] && (i + 1 == int'(used))) begin
        chain_fin = 1'b1;
        chain_acc = cell_acc[i];
      end
    end
  end

  assign fin      = chain_fin || bypass;
  assign fin_acc  = bypass ? acc_first : chain_acc;
  assign fin_last = bypass ? samples.last_in : last_hold;

  // Output register with one skid entry.
  assign pop              = out_valid && results.ready;
  assign results.valid    = out_valid;
  assign results.sample_out = out_data;
  assign results.last_out = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        out_last   <= skid_last;
        skid_valid <= 1'b0;
      end
    end else if (fin) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
        out_data  <= fin_acc[OUT_LSB +: DATA_W];
        out_last  <= fin_last;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= fin_acc[OUT_LSB +: DATA_W];
        skid_last  <= fin_last;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_one_cell_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_done))
    else $error("more than one section finished in the same cycle");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_fin_when_busy: assert property (@(posedge clk) disable iff (rst)
    chain_fin |-> (state == CORE_BUSY))
    else $error("chain finished with no sample in flight");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (fin && skid_valid) |-> 1'b0)
    else $error("result finished while skid entry full");

endmodule

### hw/rtl/cbq_cell.sv
// One biquad section: its coefficients, its two delays and a shared multiplier.
module cbq_cell #(
  parameter int SECTION_IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cbq_pkg::ACC_W-1:0]         acc_in,
  input  cbq_pkg::cbq_coef_wr_t             coef_wr,
  output logic                              done,
  output logic [cbq_pkg::ACC_W-1:0]         acc_out
);
  import cbq_pkg::*;

  localparam int BASE = SECTION_IDX * COEFS_PER_SECTION;

  cbq_step_t                state, state_next;
  logic signed [DATA_W-1:0] coef [COEFS_PER_SECTION];
  logic signed [DATA_W-1:0] w1, w2, w0;
  logic [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]  prod;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [ACC_W-1:0]         prod2;
  logic signed [DATA_W-1:0] w0_new;

  assign prod2   = ACC_W'(prod) << 1;
  assign w0_new  = acc[W0_LSB +: DATA_W];
  assign acc_out = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    mul_a      = w1;
    mul_b      = coef[POS_A1];
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_A1;
      end
      ST_A1: begin
        mul_a      = w2;
        mul_b      = coef[POS_A2];
        state_next = ST_A2;
      end
      ST_A2: begin
        mul_a      = w2;
        mul_b      = coef[POS_B2];
        state_next = ST_W0;
      end
      ST_W0: begin
        mul_a      = w0_new;
        mul_b      = coef[POS_B0];
        state_next = ST_B0;
      end
      ST_B0: begin
        mul_a      = w1;
        mul_b      = coef[POS_B1];
        state_next = ST_B1;
      end
      ST_B1: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Accumulator and product register; product is always one step behind.
  always_ff @(posedge clk) begin
    prod <= ACC_W'(mul_a * mul_b);
    case (state)
      ST_IDLE: if (start) acc <= acc_in;
      ST_A1:   acc <= acc - prod2;
      ST_A2:   acc <= acc - prod2 + W0_ROUND;
      ST_W0: begin
        w0  <= w0_new;
        acc <= prod2;
      end
      ST_B0:   acc <= acc + prod2;
      ST_B1:   acc <= acc + prod2 + OUT_ROUND;
      default: acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= '0;
      w2 <= '0;
      for (int p = 0; p < COEFS_PER_SECTION; p++) coef[p] <= '0;
    end else begin
      if (state == ST_B1) begin
        w2 <= w1;
        w1 <= w0;
      end
      for (int p = 0; p < COEFS_PER_SECTION; p++) begin
        if (coef_wr.en && int'(coef_wr.index) == BASE + p) coef[p] <= coef_wr.value;
      end
    end
  end

endmodule
